FILE: hdl/pdh_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pdh_pkg
// Shared types and constants of the pair distance histogram engine.
// ---------------------------------------------------------------------------
package pdh_pkg;

  localparam int COORD_W = 24;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 48;
  localparam int ROOT_W  = 24;
  localparam int STEPS   = 24;
  localparam int STEP_W  = 5;
  localparam int NUM_HIST = 4;
  localparam int BIN_SHIFT = 28;
  localparam int RAW_BIN_W = 20;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] BIN_INC = 32'd2;

  localparam logic [COORD_W-1:0] RST_BOX = 24'hFFFFFF;
  localparam logic [COORD_W-1:0] RST_INV = 24'd65536;

  localparam logic [1:0] OP_BIN    = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] CLS_WATER   = 2'd0;
  localparam logic [1:0] CLS_ION_WAT = 2'd1;
  localparam logic [1:0] CLS_ION_ION = 2'd2;

  localparam logic [1:0] HIST_WATER  = 2'd0;
  localparam logic [1:0] HIST_ANION  = 2'd1;
  localparam logic [1:0] HIST_CATION = 2'd2;
  localparam logic [1:0] HIST_ION    = 2'd3;

  localparam logic [1:0] REG_BOX_XY = 2'd0;
  localparam logic [1:0] REG_BOX_Z  = 2'd1;
  localparam logic [1:0] REG_INV    = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_FOLD, ST_SQR, ST_SUM,
    ST_ROOT, ST_MUL, ST_BIN, ST_RD, ST_WR, ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/pair_distance_histogram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pair_distance_histogram
// Minimum-image pair distance binning into four saturating histograms.
// ---------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_ready  op, class, anion flag, two points, read select
// out_     output     out_valid/out_ready bin_count, sample_count, pair_binned, bin_index
// cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// One transaction is worked at a time. A pair passes through the shared-step
// restoring divisions that fold the three axes, squaring, the bitwise square
// root, scaling and the memory read-modify-write. A clear walks the histogram
// memory one entry per cycle. After reset the same clearing pass runs before
// in_ready rises; configuration writes are taken during it. A stalled result
// waits in the output register while the next transaction is accepted.
module pair_distance_histogram
  import pdh_pkg::*;
#(
  parameter int BINS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [COORD_W-1:0] cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_op,
  input  wire logic [1:0]         in_pair_class,
  input  wire logic               in_ion_is_anion,
  input  wire logic [COORD_W-1:0] in_ax,
  input  wire logic [COORD_W-1:0] in_ay,
  input  wire logic [COORD_W-1:0] in_az,
  input  wire logic [COORD_W-1:0] in_bx,
  input  wire logic [COORD_W-1:0] in_by_coord,
  input  wire logic [COORD_W-1:0] in_bz,
  input  wire logic [1:0]         in_read_histogram,
  input  wire logic [7:0]         in_read_bin,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CNT_W-1:0]        out_bin_count,
  output logic [CNT_W-1:0]        out_sample_count,
  output logic                    out_pair_binned,
  output logic [7:0]              out_bin_index
);

  localparam int DEPTH  = NUM_HIST * BINS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Configuration registers.
  logic [COORD_W-1:0] box_xy_r, box_z_r, inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_xy_r <= RST_BOX;
      box_z_r  <= RST_BOX;
      inv_r    <= RST_INV;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_XY: box_xy_r <= cfg_wdata;
        REG_BOX_Z:  box_z_r  <= cfg_wdata;
        REG_INV:    inv_r    <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Control and datapath registers.
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               clr_reply_r, clr_reply_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]   samples_r, samples_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [1:0]         hist_r, hist_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [COORD_W-1:0] m_r [3];
  logic [COORD_W-1:0] m_nxt [3];
  logic [COORD_W-1:0] rem_r [3];
  logic [COORD_W-1:0] rem_nxt [3];
  logic [22:0]        dist_r [3];
  logic [22:0]        dist_nxt [3];
  logic [45:0]        sq_r [3];
  logic [45:0]        sq_nxt [3];
  logic [SUM_W-1:0]   s_r, s_nxt;
  logic [25:0]        rt_rem_r, rt_rem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [47:0]        prod_r, prod_nxt;
  logic [7:0]         bin_r, bin_nxt;
  logic [CNT_W-1:0]   res_count_r, res_count_nxt;
  logic               res_binned_r, res_binned_nxt;
  logic [CNT_W-1:0]   ob_count_r, ob_count_nxt;
  logic [CNT_W-1:0]   os_count_r, os_count_nxt;
  logic               ob_binned_r, ob_binned_nxt;
  logic [7:0]         ob_index_r, ob_index_nxt;

  // Histogram memory.
  logic [CNT_W-1:0]  mem [DEPTH];
  logic [CNT_W-1:0]  mem_q_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [CNT_W-1:0]  mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[addr_r];
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_bin_count    = ob_count_r;
  assign out_sample_count = os_count_r;
  assign out_pair_binned  = ob_binned_r;
  assign out_bin_index    = ob_index_r;

  always_comb begin
    logic [COORD_W-1:0] lens [3];
    logic [COORD_W-1:0] pa [3];
    logic [COORD_W-1:0] pb [3];
    logic [COORD_W:0]   trial;
    logic [COORD_W-1:0] r;
    logic               fold_ok;
    logic [27:0]        rt_shift;
    logic [27:0]        rt_trial;
    logic [RAW_BIN_W-1:0] raw_bin;
    logic [CNT_W-1:0]   sum_cnt;

    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    clr_reply_nxt  = clr_reply_r;
    clr_addr_nxt   = clr_addr_r;
    step_nxt       = step_r;
    samples_nxt    = samples_r;
    op_nxt         = op_r;
    hist_nxt       = hist_r;
    addr_nxt       = addr_r;
    m_nxt          = m_r;
    rem_nxt        = rem_r;
    dist_nxt       = dist_r;
    sq_nxt         = sq_r;
    s_nxt          = s_r;
    rt_rem_nxt     = rt_rem_r;
    root_nxt       = root_r;
    prod_nxt       = prod_r;
    bin_nxt        = bin_r;
    res_count_nxt  = res_count_r;
    res_binned_nxt = res_binned_r;
    ob_count_nxt   = ob_count_r;
    os_count_nxt   = os_count_r;
    ob_binned_nxt  = ob_binned_r;
    ob_index_nxt   = ob_index_r;
    mem_we         = 1'b0;
    mem_wa         = clr_addr_r;
    mem_wd         = '0;

    lens[0] = box_xy_r;
    lens[1] = box_xy_r;
    lens[2] = box_z_r;
    pa[0] = in_ax;
    pa[1] = in_ay;
    pa[2] = in_az;
    pb[0] = in_bx;
    pb[1] = in_by_coord;
    pb[2] = in_bz;
    fold_ok  = 1'b1;
    trial    = '0;
    r        = '0;
    rt_shift = {rt_rem_r, s_r[SUM_W-1 -: 2]};
    rt_trial = {2'b00, root_r, 2'b01};
    raw_bin  = prod_r[BIN_SHIFT +: RAW_BIN_W];
    sum_cnt  = (mem_q_r > CNT_MAX - BIN_INC) ? CNT_MAX : mem_q_r + BIN_INC;

    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          clr_addr_nxt = '0;
          state_nxt = clr_reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_op;
          res_count_nxt  = '0;
          res_binned_nxt = 1'b0;
          bin_nxt        = '0;
          step_nxt       = '0;
          for (int i = 0; i < 3; i++) begin
            m_nxt[i]   = (pa[i] >= pb[i]) ? pa[i] - pb[i] : pb[i] - pa[i];
            rem_nxt[i] = '0;
          end
          case (in_pair_class)
            CLS_WATER:   hist_nxt = HIST_WATER;
            CLS_ION_WAT: hist_nxt = in_ion_is_anion ? HIST_ANION : HIST_CATION;
            default:     hist_nxt = HIST_ION;
          endcase
          case (in_op)
            OP_BIN: begin
              // Pair class three selects no histogram.
              state_nxt = (in_pair_class == 2'd3) ? ST_DONE : ST_DIV;
            end
            OP_SAMPLE: begin
              if (samples_r != CNT_MAX) begin
                samples_nxt = samples_r + 1'b1;
              end
              state_nxt = ST_DONE;
            end
            OP_READ: begin
              addr_nxt = ADDR_W'(in_read_histogram) * ADDR_W'(BINS) + ADDR_W'(in_read_bin);
              state_nxt = (32'(in_read_bin) < BINS) ? ST_RD : ST_DONE;
            end
            default: begin
              clr_reply_nxt = 1'b1;
              clr_addr_nxt  = '0;
              state_nxt     = ST_CLEAR;
            end
          endcase
        end
      end
      ST_DIV: begin
        // One restoring division step per axis: remainder of m by the box.
        for (int i = 0; i < 3; i++) begin
          trial = {rem_r[i], m_r[i][COORD_W-1]};
          if (trial >= {1'b0, lens[i]}) begin
            trial = trial - {1'b0, lens[i]};
          end
          rem_nxt[i] = trial[COORD_W-1:0];
          m_nxt[i]   = {m_r[i][COORD_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(STEPS - 1)) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        // Round to the nearest image, then require the distance below half a box.
        for (int i = 0; i < 3; i++) begin
          r = ({rem_r[i], 1'b0} < {1'b0, lens[i]}) ? rem_r[i] : lens[i] - rem_r[i];
          dist_nxt[i] = r[22:0];
          if (lens[i] == '0 || {r, 1'b0} >= {1'b0, lens[i]}) begin
            fold_ok = 1'b0;
          end
        end
        state_nxt = fold_ok ? ST_SQR : ST_DONE;
      end
      ST_SQR: begin
        for (int i = 0; i < 3; i++) begin
          sq_nxt[i] = dist_r[i] * dist_r[i];
        end
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        s_nxt = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
        rt_rem_nxt = '0;
        root_nxt   = '0;
        step_nxt   = '0;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        // Bitwise square root, two radicand bits per step.
        if (rt_shift >= rt_trial) begin
          rt_rem_nxt = 26'(rt_shift - rt_trial);
          root_nxt   = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rt_rem_nxt = rt_shift[25:0];
          root_nxt   = {root_r[ROOT_W-2:0], 1'b0};
        end
        s_nxt    = {s_r[SUM_W-3:0], 2'b00};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(STEPS - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = root_r * inv_r;
        state_nxt = ST_BIN;
      end
      ST_BIN: begin
        bin_nxt  = raw_bin[7:0];
        addr_nxt = ADDR_W'(hist_r) * ADDR_W'(BINS) + ADDR_W'(raw_bin);
        state_nxt = (raw_bin < RAW_BIN_W'(BINS)) ? ST_RD : ST_DONE;
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        if (op_r == OP_BIN) begin
          mem_we         = 1'b1;
          mem_wa         = addr_r;
          mem_wd         = sum_cnt;
          res_count_nxt  = sum_cnt;
          res_binned_nxt = 1'b1;
        end else begin
          res_count_nxt = mem_q_r;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          ob_count_nxt  = res_count_r;
          os_count_nxt  = samples_r;
          ob_binned_nxt = res_binned_r;
          ob_index_nxt  = res_binned_r ? bin_r : 8'd0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      clr_reply_r <= 1'b0;
      clr_addr_r  <= '0;
      step_r      <= '0;
      samples_r   <= '0;
      addr_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_reply_r <= clr_reply_nxt;
      clr_addr_r  <= clr_addr_nxt;
      step_r      <= step_nxt;
      samples_r   <= samples_nxt;
      addr_r      <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    hist_r       <= hist_nxt;
    m_r          <= m_nxt;
    rem_r        <= rem_nxt;
    dist_r       <= dist_nxt;
    sq_r         <= sq_nxt;
    s_r          <= s_nxt;
    rt_rem_r     <= rt_rem_nxt;
    root_r       <= root_nxt;
    prod_r       <= prod_nxt;
    bin_r        <= bin_nxt;
    res_count_r  <= res_count_nxt;
    res_binned_r <= res_binned_nxt;
    ob_count_r   <= ob_count_nxt;
    os_count_r   <= os_count_nxt;
    ob_binned_r  <= ob_binned_nxt;
    ob_index_r   <= ob_index_nxt;
  end

  // A binned pair always reports a count of at least one increment.
  a_binned_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ob_binned_r |-> ob_count_r >= BIN_INC)
    else $error("binned pair reported a count below one increment");

  // The sample counter never moves backward.
  a_samples_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> samples_r >= $past(samples_r))
    else $error("sample counter decreased");

  // The memory is only written by the clearing pass or the pair update.
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == ST_CLEAR || (state_r == ST_WR && op_r == OP_BIN))
    else $error("histogram write outside clear or pair update");

endmodule
`default_nettype wire
